// File: sv/bffa_pkg.sv
`timescale 1ns / 1ps

package bffa_pkg;

    localparam int unsigned COMMAND_W = 2;
    localparam int unsigned INDEX_W   = 13;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned NUMBER_W  = 14;
    localparam int unsigned LIMIT_W   = 14;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned BITSEL_W  = 5;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 14'd8192;

    localparam logic [COMMAND_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [COMMAND_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [COMMAND_W-1:0] CMD_TEST    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_BIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [NUMBER_W-1:0] number;
        logic                bit_was;
    } t_result;

endpackage

// File: sv/bffa_cmd_if.sv
`timescale 1ns / 1ps

interface bffa_cmd_if;
    import bffa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [COMMAND_W-1:0] command;
    logic [INDEX_W-1:0]   index;

    modport source (output valid, output command, output index, input ready);
    modport sink (input valid, input command, input index, output ready);
endinterface

// File: sv/bffa_res_if.sv
`timescale 1ns / 1ps

interface bffa_res_if;
    import bffa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NUMBER_W-1:0] number;
    logic                bit_was;

    modport source (output valid, output status, output number, output bit_was, input ready);
    modport sink (input valid, input status, input number, input bit_was, output ready);
endinterface

// File: sv/bffa_cfg_if.sv
`timescale 1ns / 1ps

interface bffa_cfg_if;
    import bffa_pkg::*;

    logic               valid;
    logic               ready;
    logic [LIMIT_W-1:0] entry_limit;

    modport source (output valid, output entry_limit, input ready);
    modport sink (input valid, input entry_limit, output ready);
endinterface

// File: sv/bitmap_first_free_allocator_unit.sv
`timescale 1ns / 1ps

// First-fit allocator over a usage bitmap held as 32-bit words in one single-port-write,
// registered-read memory. After reset a clearing pass writes every word to zero, one word a
// cycle (ceil(BITMAP_BITS/32) words, 256 at the default size); commands are held off until it
// ends, configuration writes are taken throughout. An allocate reads the words from word 0 on,
// one per cycle, and a single 32-bit first-free search over the word just read finds the
// entry; the scan stops at the word that holds the last entry under the effective limit,
// min(entry_limit, BITMAP_BITS). Release and test read the word that holds the indexed bit,
// and a release writes it back with that bit cleared; an index out of range, an unused command
// code or an allocate under a zero limit goes straight to its result. One command is in
// flight at a time; a new command is accepted while the previous result still waits in the
// output register, and its own result waits in the block until that register is free.
module bitmap_first_free_allocator_unit #(
    parameter int unsigned BITMAP_BITS = 8192
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    bffa_cfg_if.sink          i_cfg,
    bffa_cmd_if.sink          i_cmd,
    bffa_res_if.source        o_res
);
    import bffa_pkg::*;

    localparam int unsigned WORDS = (BITMAP_BITS + WORD_W - 1) / WORD_W;
    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [31:0] BITS32     = 32'(BITMAP_BITS);
    localparam logic [AW-1:0] LAST_WORD = AW'(WORDS - 1);

    logic [WORD_W-1:0] r_bitmap [WORDS];
    logic [WORD_W-1:0] r_rd_data;

    t_state             r_state, n_state;
    logic [AW-1:0]      r_word, n_word;
    logic [AW-1:0]      r_last_word, n_last_word;
    logic [COMMAND_W-1:0] r_cmd, n_cmd;
    logic [INDEX_W-1:0] r_idx, n_idx;
    t_result            r_res, n_res;
    t_result            r_out;
    logic               r_out_valid;
    logic [LIMIT_W-1:0] r_entry_limit;

    logic [LIMIT_W-1:0] w_lim;
    logic               w_in_xfer;
    logic               w_can_emit;
    logic               w_load_out;
    logic               w_rd_en;
    logic [AW-1:0]      w_rd_addr;
    logic               w_wr_en;
    logic [AW-1:0]      w_wr_addr;
    logic [WORD_W-1:0]  w_wr_data;
    logic [31:0]        w_in_word32;
    logic [31:0]        w_idx_word32;
    logic [31:0]        w_last32;
    logic [31:0]        w_rel;
    logic [WORD_W-1:0]  w_valid_mask;
    logic [WORD_W-1:0]  w_free;
    logic               w_found;
    logic [BITSEL_W-1:0] w_pos;
    logic [WORD_W-1:0]  w_idx_bit;

    function automatic logic [BITSEL_W-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [BITSEL_W-1:0] p;
        p = '0;
        for (int b = WORD_W - 1; b >= 0; b--) begin
            if (v[b]) begin
                p = BITSEL_W'(b);
            end
        end
        return p;
    endfunction

    // effective limit saturates at the bitmap size
    assign w_lim = (32'(r_entry_limit) > BITS32) ? BITS32[LIMIT_W-1:0] : r_entry_limit;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_in_xfer   = i_cmd.valid && i_cmd.ready;
    assign w_can_emit  = !r_out_valid || o_res.ready;

    assign o_res.valid   = r_out_valid;
    assign o_res.status  = r_out.status;
    assign o_res.number  = r_out.number;
    assign o_res.bit_was = r_out.bit_was;

    assign w_in_word32  = 32'(i_cmd.index) >> BITSEL_W;
    assign w_idx_word32 = 32'(r_idx) >> BITSEL_W;
    assign w_last32     = (32'(w_lim) - 32'd1) >> BITSEL_W;
    assign w_idx_bit    = WORD_W'(1) << r_idx[BITSEL_W-1:0];

    // entries at or past the limit in the current word count as taken
    assign w_rel        = 32'(w_lim) - (32'(r_word) << BITSEL_W);
    assign w_valid_mask = (w_rel >= 32'(WORD_W)) ? '1
                        : ((WORD_W'(1) << w_rel[BITSEL_W-1:0]) - WORD_W'(1));
    assign w_free       = ~r_rd_data & w_valid_mask;
    assign w_found      = |w_free;
    assign w_pos        = first_set(w_free);

    always_comb begin
        n_state     = r_state;
        n_word      = r_word;
        n_last_word = r_last_word;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_res       = r_res;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_word;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_word;
        w_wr_data   = '0;
        w_load_out  = 1'b0;

        unique case (r_state)
            S_CLEAR: begin
                w_wr_en = 1'b1;
                if (r_word == LAST_WORD) begin
                    n_word  = '0;
                    n_state = S_IDLE;
                end else begin
                    n_word = r_word + AW'(1);
                end
            end
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd = i_cmd.command;
                    n_idx = i_cmd.index;
                    n_res = '0;
                    if (i_cmd.command == CMD_ALLOC) begin
                        if (w_lim == '0) begin
                            n_res.status = ST_NO_FREE;
                            n_state      = S_EMIT;
                        end else begin
                            n_word      = '0;
                            n_last_word = w_last32[AW-1:0];
                            w_rd_en     = 1'b1;
                            w_rd_addr   = '0;
                            n_state     = S_SCAN;
                        end
                    end else if (i_cmd.command == CMD_RELEASE || i_cmd.command == CMD_TEST) begin
                        if (LIMIT_W'(i_cmd.index) >= w_lim) begin
                            n_res.status = ST_RANGE;
                            n_state      = S_EMIT;
                        end else begin
                            w_rd_en   = 1'b1;
                            w_rd_addr = w_in_word32[AW-1:0];
                            n_state   = S_BIT;
                        end
                    end else begin
                        // unused command code: empty result, bitmap untouched
                        n_state = S_EMIT;
                    end
                end
            end
            S_SCAN: begin
                if (w_found) begin
                    w_wr_en      = 1'b1;
                    w_wr_data    = r_rd_data | (WORD_W'(1) << w_pos);
                    n_res.number = NUMBER_W'((32'(r_word) << BITSEL_W) + 32'(w_pos) + 32'd1);
                    n_state      = S_EMIT;
                end else if (r_word == r_last_word) begin
                    n_res.status = ST_NO_FREE;
                    n_state      = S_EMIT;
                end else begin
                    n_word    = r_word + AW'(1);
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_word + AW'(1);
                end
            end
            S_BIT: begin
                n_res.bit_was = r_rd_data[r_idx[BITSEL_W-1:0]];
                if (r_cmd == CMD_RELEASE) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_idx_word32[AW-1:0];
                    w_wr_data = r_rd_data & ~w_idx_bit;
                end
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (w_can_emit) begin
                    w_load_out = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_bitmap[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_bitmap[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_word        <= '0;
            r_out_valid   <= 1'b0;
            r_entry_limit <= LIMIT_RESET;
        end else begin
            r_state <= n_state;
            r_word  <= n_word;
            if (i_cfg.valid && i_cfg.ready) begin
                r_entry_limit <= i_cfg.entry_limit;
            end
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_last_word <= n_last_word;
        r_cmd       <= n_cmd;
        r_idx       <= n_idx;
        r_res       <= n_res;
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

`ifndef SYNTHESIS
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_word <= r_last_word))
        else $error("allocation scan ran past the last word");

    a_write_states: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_CLEAR || r_state == S_SCAN || r_state == S_BIT))
        else $error("bitmap written outside clear, scan or bit update");

    a_number_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.number != '0) |-> (o_res.status == ST_OK && !o_res.bit_was))
        else $error("allocated number with a non-ok status or a set bit");

    a_emit_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && w_can_emit) |=> (r_out_valid && r_state == S_IDLE))
        else $error("finished result not moved to the output register");
`endif

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
    import bffa_pkg::*;

    localparam int unsigned BITMAP_BITS  = 8192;
    localparam int unsigned HOLD_CYCLES  = 400;
    localparam int unsigned QUIET_LIMIT  = 5000;
    localparam int unsigned SETTLE_TICKS = 300;

    // command code 3 has no name in the package: the block treats it as a no-op
    localparam logic [COMMAND_W-1:0] CMD_NOP = 2'd3;

    typedef enum int {
        IDLE_RX_HEAVY,
        IDLE_TX_HEAVY,
        IDLE_NONE
    } t_idle_mode;

    typedef struct packed {
        logic [COMMAND_W-1:0] command;
        logic [INDEX_W-1:0]   index;
    } t_request;

    logic i_clk = 1'b0;
    logic i_rst_n;

    bffa_cfg_if cfg_if ();
    bffa_cmd_if cmd_if ();
    bffa_res_if res_if ();

    bitmap_first_free_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_if.sink),
        .i_cmd   (cmd_if.sink),
        .o_res   (res_if.source)
    );

    // shadow of the block: usage bits and the entry limit
    bit                 usage_map [BITMAP_BITS];
    logic [LIMIT_W-1:0] limit_now = LIMIT_RESET;

    t_request    requests_waiting [$];
    t_result     results_due [$];
    t_request    next_request;
    t_result     oldest_due;
    int unsigned requests_outstanding = 0;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned hold_requests = 0;
    int unsigned hold_served = 0;
    int unsigned hold_left = 0;
    t_idle_mode  idle_mode = IDLE_RX_HEAVY;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned span_of(input logic [LIMIT_W-1:0] limit);
        return (limit > BITMAP_BITS) ? BITMAP_BITS : int'(limit);
    endfunction

    // first fit over the shadow bitmap, updating it as the block would
    function automatic t_result predict_result(input logic [COMMAND_W-1:0] command,
                                               input logic [INDEX_W-1:0] index);
        t_result     r;
        int unsigned span;
        r = '0;
        span = span_of(limit_now);
        if (command == CMD_ALLOC) begin
            r.status = ST_NO_FREE;
            for (int unsigned p = 0; p < span; p++) begin
                if (!usage_map[p]) begin
                    usage_map[p] = 1'b1;
                    r.status = ST_OK;
                    r.number = NUMBER_W'(p + 1);
                    break;
                end
            end
        end else if (command == CMD_RELEASE || command == CMD_TEST) begin
            if (index >= span) begin
                r.status = ST_RANGE;
            end else begin
                r.bit_was = usage_map[index];
                if (command == CMD_RELEASE) begin
                    usage_map[index] = 1'b0;
                end
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    function automatic bit sender_pauses();
        case (idle_mode)
            IDLE_RX_HEAVY: return $urandom_range(0, 99) < 35;
            IDLE_TX_HEAVY: return $urandom_range(0, 99) < 62;
            default:       return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_pauses();
        case (idle_mode)
            IDLE_RX_HEAVY: return $urandom_range(0, 99) < 62;
            IDLE_TX_HEAVY: return $urandom_range(0, 99) < 35;
            default:       return 1'b0;
        endcase
    endfunction

    // command driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                results_due.push_back(predict_result(cmd_if.command, cmd_if.index));
                requests_outstanding--;
            end
            if (!cmd_if.valid || cmd_if.ready) begin
                if (requests_waiting.size() != 0 && !sender_pauses()) begin
                    next_request = requests_waiting.pop_front();
                    cmd_if.valid   <= 1'b1;
                    cmd_if.command <= next_request.command;
                    cmd_if.index   <= next_request.index;
                end else begin
                    cmd_if.valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, started on request from the stimulus
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_requests;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (results_due.size() == 0) begin
                    report_mismatch($sformatf(
                        "result with nothing outstanding (status %0d number %0d)",
                        res_if.status, res_if.number));
                end else begin
                    oldest_due = results_due.pop_front();
                    if (res_if.status !== oldest_due.status) begin
                        report_mismatch($sformatf("status got %0d want %0d",
                                                  res_if.status, oldest_due.status));
                    end
                    if (res_if.number !== oldest_due.number) begin
                        report_mismatch($sformatf("number got %0d want %0d",
                                                  res_if.number, oldest_due.number));
                    end
                    if (res_if.bit_was !== oldest_due.bit_was) begin
                        report_mismatch($sformatf("bit_was got %0b want %0b",
                                                  res_if.bit_was, oldest_due.bit_was));
                    end
                end
            end
            res_if.ready <= (hold_left == 0) && !receiver_pauses();
        end
    end

    // watchdog on cycles with no transfer on any channel
    always @(posedge i_clk) begin
        if (!i_rst_n || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)
                || (cfg_if.valid && cfg_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_request(input logic [COMMAND_W-1:0] command,
                                input logic [INDEX_W-1:0] index);
        t_request q;
        q.command = command;
        q.index   = index;
        requests_outstanding++;
        requests_waiting.push_back(q);
    endtask

    task automatic wait_drained();
        while (requests_outstanding != 0 || results_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid       <= 1'b1;
        cfg_if.entry_limit <= value;
        do begin
            @(posedge i_clk);
        end while (!cfg_if.ready);
        limit_now = value;
        cfg_if.valid <= 1'b0;
    endtask

    // indices mostly land where allocations live, some anywhere in the field
    function automatic logic [INDEX_W-1:0] pick_index(input int unsigned span);
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (span == 0 || roll < 20) begin
            return INDEX_W'($urandom_range(0, BITMAP_BITS - 1));
        end else if (roll < 60) begin
            return INDEX_W'($urandom_range(0, ((span > 256) ? 256 : span) - 1));
        end
        return INDEX_W'($urandom_range(0, span - 1));
    endfunction

    task automatic push_random(input int unsigned span, input int unsigned alloc_pct);
        int unsigned roll;
        logic [COMMAND_W-1:0] command;
        roll = $urandom_range(0, 99);
        if (roll < alloc_pct) begin
            command = CMD_ALLOC;
        end else if (roll < 97) begin
            command = $urandom_range(0, 1) ? CMD_RELEASE : CMD_TEST;
        end else begin
            command = CMD_NOP;
        end
        push_request(command, pick_index(span));
    endtask

    task automatic run_phase(input logic [LIMIT_W-1:0] limit, input int unsigned count,
                             input int unsigned alloc_pct, input bit hold_rx);
        int unsigned span;
        write_limit(limit);
        span = span_of(limit);
        if (hold_rx) begin
            hold_requests++;
        end
        for (int unsigned n = 0; n < count; n++) begin
            // sender stops half way until every result is back
            if (n == count / 2) begin
                wait_drained();
            end
            push_random(span, alloc_pct);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n            = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.entry_limit = '0;
        cmd_if.valid       = 1'b0;
        cmd_if.command     = CMD_ALLOC;
        cmd_if.index       = '0;
        res_if.ready       = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset limit: first fit, release of a clear bit, top index, no-op
        push_request(CMD_ALLOC, 13'd0);
        push_request(CMD_ALLOC, 13'd8191);
        push_request(CMD_ALLOC, 13'd4660);
        push_request(CMD_TEST, 13'd0);
        push_request(CMD_TEST, 13'd8191);
        push_request(CMD_RELEASE, 13'd1);
        push_request(CMD_RELEASE, 13'd1);
        push_request(CMD_ALLOC, 13'd2730);
        push_request(CMD_NOP, 13'd8191);
        push_request(CMD_RELEASE, 13'd8191);
        push_request(CMD_TEST, 13'd5461);
        wait_drained();

        // zero limit: no free entry, every index out of range
        write_limit(14'd0);
        push_request(CMD_ALLOC, 13'd0);
        push_request(CMD_RELEASE, 13'd0);
        push_request(CMD_TEST, 13'd8191);
        wait_drained();

        // limit above the bitmap size saturates
        write_limit(14'd16383);
        push_request(CMD_TEST, 13'd8191);
        push_request(CMD_ALLOC, 13'd0);
        wait_drained();

        // single entry
        write_limit(14'd1);
        push_request(CMD_ALLOC, 13'd0);
        push_request(CMD_RELEASE, 13'd0);
        push_request(CMD_ALLOC, 13'd0);
        push_request(CMD_TEST, 13'd1);
        wait_drained();

        run_phase(14'd40, 200, 60, 1'b0);
        run_phase(14'd8192, 150, 50, 1'b0);
        run_phase(14'd100, 200, 70, 1'b1);

        idle_mode = IDLE_TX_HEAVY;
        run_phase(14'd1, 60, 50, 1'b0);
        run_phase(14'd16383, 150, 50, 1'b0);
        run_phase(14'd64, 200, 80, 1'b1);

        idle_mode = IDLE_NONE;
        run_phase(LIMIT_W'($urandom_range(2, 8191)), 200, 55, 1'b0);
        run_phase(14'd0, 40, 40, 1'b0);
        run_phase(14'd300, 250, 75, 1'b1);
        run_phase(14'd8192, 200, 50, 1'b0);
        run_phase(14'd33, 150, 60, 1'b0);
        run_phase(14'd8193, 100, 50, 1'b0);

        repeat (SETTLE_TICKS) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/bffa_pkg.sv
sv/bffa_cmd_if.sv
sv/bffa_res_if.sv
sv/bffa_cfg_if.sv
sv/bitmap_first_free_allocator_unit.sv
tb/tb.sv
